/* rtl/ctf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctf_pkg
// Shared types, constants and helper functions of the complementary tilt
// filter.
// ----------------------------------------------------------------------------
package ctf_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ANGLE_BITS_DEF   = 16;
    localparam int TABLE_LEN        = 24;
    localparam int SQRT_STEPS       = 26;
    localparam int STEP_W           = 5;
    localparam int CFG_AW           = 2;
    localparam int CFG_DW           = 16;

    localparam logic [CFG_AW-1:0] REG_BLEND_WEIGHT  = 2'd0;
    localparam logic [CFG_AW-1:0] REG_RATE_OFFSET_Y = 2'd1;
    localparam logic [CFG_AW-1:0] REG_RATE_OFFSET_Z = 2'd2;

    localparam logic [15:0] BLEND_WEIGHT_RST = 16'd64225;

    localparam logic [31:0] ATAN_Q30 [TABLE_LEN] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F};

    typedef struct packed {
        logic              load;
        logic              mul;
        logic              prep;
        logic              iter;
        logic              cinit;
        logic              cord;
        logic              rnd;
        logic              blend;
        logic              fin;
        logic              emit;
        logic              axis;
        logic [STEP_W-1:0] step;
    } ctf_cmd_t;

    typedef struct packed {
        logic out_full;
    } ctf_status_t;

    function automatic logic [63:0] atan_entry(input logic [STEP_W-1:0] i, input int ab);
        logic [63:0] t;
        t = 64'd0;
        if (i < STEP_W'(TABLE_LEN)) begin
            t = {32'd0, ATAN_Q30[i]};
        end
        if (ab <= 30) begin
            return t >> (30 - ab);
        end
        return t << (ab - 30);
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
        if (v > 64'sd32767) begin
            return 16'sh7FFF;
        end
        if (v < -64'sd32768) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

endpackage

/* rtl/ctf_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctf_ctrl
// Sequencer of the tilt filter: walks the pitch axis, then the roll axis,
// through products, square root and division, CORDIC, rounding and blending.
// ----------------------------------------------------------------------------
module ctf_ctrl
    import ctf_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  ctf_status_t status,
    output ctf_cmd_t    cmd
);

    localparam int NSTEP = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_MUL   = 10'b0000000010,
        ST_PREP  = 10'b0000000100,
        ST_ITER  = 10'b0000001000,
        ST_CINIT = 10'b0000010000,
        ST_CORD  = 10'b0000100000,
        ST_RND   = 10'b0001000000,
        ST_BLEND = 10'b0010000000,
        ST_FIN   = 10'b0100000000,
        ST_DONE  = 10'b1000000000
    } state_t;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              axis_reg, axis_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            axis_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            axis_reg  <= axis_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        axis_next  = axis_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.axis   = axis_reg;
        cmd.step   = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    axis_next  = 1'b0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_PREP;
            end
            ST_PREP: begin
                cmd.prep   = 1'b1;
                cnt_next   = '0;
                state_next = ST_ITER;
            end
            ST_ITER: begin
                cmd.iter = 1'b1;
                if (cnt_reg == STEP_W'(SQRT_STEPS - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_CINIT;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_CINIT: begin
                cmd.cinit  = 1'b1;
                cnt_next   = '0;
                state_next = ST_CORD;
            end
            ST_CORD: begin
                cmd.cord = 1'b1;
                if (cnt_reg == STEP_W'(NSTEP - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_RND;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_RND: begin
                cmd.rnd    = 1'b1;
                state_next = ST_BLEND;
            end
            ST_BLEND: begin
                cmd.blend  = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                cmd.fin = 1'b1;
                if (axis_reg) begin
                    state_next = ST_DONE;
                end else begin
                    axis_next  = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_DONE: begin
                if (!status.out_full) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/ctf_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctf_datapath
// Registers, square root, reciprocal division by 1000, CORDIC and blend
// arithmetic of the tilt filter, with the configuration registers and the
// output register.
// ----------------------------------------------------------------------------
module ctf_datapath
    import ctf_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  ctf_cmd_t          cmd,
    output ctf_status_t       status,
    input  logic [111:0]      in_data,
    input  logic              cfg_we,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [CFG_DW-1:0] cfg_wdata,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [31:0]       out_data
);

    localparam int CW  = 28;
    localparam int ZW  = ANGLE_BITS + 3;
    localparam int SHR = (ANGLE_BITS > 13) ? ANGLE_BITS - 13 : 0;
    localparam int SHL = (ANGLE_BITS < 13) ? 13 - ANGLE_BITS : 0;
    localparam logic signed [63:0] RND = (ANGLE_BITS > 13) ?
        (64'sd1 <<< (ANGLE_BITS - 14)) : 64'sd0;
    localparam logic [49:0] DIV_LIMIT  = 50'd65536000;
    localparam logic [26:0] RECIP_1000 = 27'd68719477;

    logic [15:0]        weight_reg;
    logic signed [15:0] off_y_reg, off_z_reg;
    logic signed [15:0] ax_reg, ay_reg, az_reg;
    logic signed [16:0] ry_reg, rz_reg;
    logic [31:0]        dt_reg, last_stamp_reg;
    logic signed [15:0] pitch_reg, roll_reg;

    logic [31:0]        sqa_reg, sqb_reg;
    logic signed [49:0] rd_reg;
    logic [51:0]        rad_reg;
    logic [25:0]        root_reg;
    logic [26:0]        rem_reg;
    logic [25:0]        dq_reg;
    logic               neg_reg, big_reg, zero_reg;
    logic signed [CW-1:0] x_reg, y_reg;
    logic signed [ZW-1:0] z_reg;
    logic signed [15:0] tilt_reg, pred_reg;
    logic signed [32:0] pw_reg;
    logic signed [33:0] tw_reg;
    logic               out_valid_reg;
    logic [31:0]        out_data_reg;

    logic signed [15:0] sel_num, sel_a, sel_b, sel_angle;
    logic signed [16:0] sel_rate;
    logic signed [31:0] prod_a, prod_b;
    logic [32:0]        sq_sum;
    logic [48:0]        mag;
    logic [49:0]        mag5;
    logic [28:0]        rem2, trial;
    logic [52:0]        qprod;
    logic signed [CW-1:0] xs, ys;
    logic signed [ZW-1:0] tab;
    logic signed [63:0] zr;
    logic [16:0]        dmag;
    logic signed [17:0] sdelta;
    logic signed [18:0] pred_sum;
    logic signed [35:0] mix;
    logic [16:0]        wc;

    assign sel_num   = cmd.axis ? ay_reg : ax_reg;
    assign sel_a     = cmd.axis ? az_reg : ay_reg;
    assign sel_b     = cmd.axis ? ax_reg : az_reg;
    assign sel_rate  = cmd.axis ? rz_reg : ry_reg;
    assign sel_angle = cmd.axis ? roll_reg : pitch_reg;

    assign prod_a = sel_a * sel_a;
    assign prod_b = sel_b * sel_b;
    assign sq_sum = {1'b0, sqa_reg} + {1'b0, sqb_reg};
    assign mag    = rd_reg[49] ? 49'(-rd_reg) << 1 : 49'(rd_reg) << 1;
    assign mag5   = {1'b0, mag} + 50'd500;

    assign rem2  = {rem_reg, rad_reg[51:50]};
    assign trial = {1'b0, root_reg, 2'b01};
    assign qprod = {27'd0, dq_reg} * {26'd0, RECIP_1000};

    assign xs  = x_reg >>> cmd.step;
    assign ys  = y_reg >>> cmd.step;
    assign tab = ZW'(atan_entry(cmd.step, ANGLE_BITS));

    assign zr       = ((64'(z_reg) + RND) >>> SHR) <<< SHL;
    assign dmag     = big_reg ? 17'd65536 : dq_reg[16:0];
    assign sdelta   = neg_reg ? -$signed({1'b0, dmag}) : $signed({1'b0, dmag});
    assign pred_sum = 19'(sel_angle) + 19'(sdelta);
    assign wc       = 17'(18'd65536 - {2'b0, weight_reg});
    assign mix      = 36'(pw_reg) + 36'(tw_reg) + 36'sd32768;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            weight_reg     <= BLEND_WEIGHT_RST;
            off_y_reg      <= '0;
            off_z_reg      <= '0;
            last_stamp_reg <= '0;
            pitch_reg      <= '0;
            roll_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_BLEND_WEIGHT:  weight_reg <= cfg_wdata;
                    REG_RATE_OFFSET_Y: off_y_reg  <= cfg_wdata;
                    REG_RATE_OFFSET_Z: off_z_reg  <= cfg_wdata;
                    default: ;
                endcase
            end
            if (cmd.load) begin
                last_stamp_reg <= in_data[111:80];
            end
            if (cmd.fin) begin
                if (cmd.axis) begin
                    roll_reg <= sat16(64'(mix >>> 16));
                end else begin
                    pitch_reg <= sat16(64'(mix >>> 16));
                end
            end
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            ax_reg <= in_data[15:0];
            ay_reg <= in_data[31:16];
            az_reg <= in_data[47:32];
            ry_reg <= 17'($signed(in_data[63:48])) - 17'(off_y_reg);
            rz_reg <= 17'($signed(in_data[79:64])) - 17'(off_z_reg);
            dt_reg <= in_data[111:80] - last_stamp_reg;
        end
        if (cmd.mul) begin
            sqa_reg <= prod_a;
            sqb_reg <= prod_b;
            rd_reg  <= 50'(sel_rate * $signed({1'b0, dt_reg}));
        end
        if (cmd.prep) begin
            rad_reg  <= {3'b000, sq_sum, 16'd0};
            root_reg <= '0;
            rem_reg  <= '0;
            neg_reg  <= rd_reg[49];
            big_reg  <= (mag5 >= DIV_LIMIT);
            dq_reg   <= mag5[25:0];
        end
        if (cmd.iter) begin
            rad_reg <= rad_reg << 2;
            if (rem2 >= trial) begin
                rem_reg  <= 27'(rem2 - trial);
                root_reg <= {root_reg[24:0], 1'b1};
            end else begin
                rem_reg  <= rem2[26:0];
                root_reg <= {root_reg[24:0], 1'b0};
            end
        end
        if (cmd.cinit) begin
            x_reg    <= $signed({{(CW - 26){1'b0}}, root_reg});
            y_reg    <= -(CW'(sel_num) <<< 8);
            z_reg    <= '0;
            zero_reg <= (root_reg == '0) && (sel_num == '0);
            dq_reg   <= {9'd0, qprod[52:36]};
        end
        if (cmd.cord) begin
            if (!y_reg[CW-1]) begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + tab;
            end else begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - tab;
            end
        end
        if (cmd.rnd) begin
            tilt_reg <= zero_reg ? 16'sd0 : sat16(zr);
            pred_reg <= sat16(64'(pred_sum));
        end
        if (cmd.blend) begin
            pw_reg <= $signed({1'b0, weight_reg}) * pred_reg;
            tw_reg <= $signed({1'b0, wc}) * tilt_reg;
        end
        if (cmd.emit) begin
            out_data_reg <= {roll_reg, pitch_reg};
        end
    end

    assign status.out_full = out_valid_reg && !out_ready;
    assign out_valid       = out_valid_reg;
    assign out_data        = out_data_reg;

endmodule

/* rtl/imu_complementary_tilt_filter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_complementary_tilt_filter
// Pitch and roll complementary filter for a six-axis IMU stream.
// ----------------------------------------------------------------------------
// Each input transfer is one IMU sample; each produces one output transfer
// with the fused pitch and roll in Q2.13 radians. The next sample is taken
// only after the last one is finished: both axes share one datapath, and per
// axis a 26-step square root and the CORDIC iterations run in turn, with the
// division by 1000 done by a reciprocal multiply. A finished result waits
// in the output register while the next sample is accepted. Configuration
// must be written only while the block is idle; the block does not enforce it.
module imu_complementary_tilt_filter
    import ctf_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
    parameter int ANGLE_BITS   = ANGLE_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    // accel_x, accel_y, accel_z, rate_y, rate_z, stamp_ms
    input  logic [111:0]      s_tdata,
    output logic              m_tvalid,
    input  logic              m_tready,
    // pitch_out, roll_out
    output logic [31:0]       m_tdata,
    input  logic              cfg_we,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [CFG_DW-1:0] cfg_wdata
);

    ctf_cmd_t    cmd;
    ctf_status_t status;

    ctf_ctrl #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_valid(s_tvalid),
        .in_ready(s_tready),
        .status  (status),
        .cmd     (cmd)
    );

    ctf_datapath #(
        .ANGLE_BITS(ANGLE_BITS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .in_data  (s_tdata),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_data (m_tdata)
    );

endmodule
